// ===== hdl/led_strip_wave_engine_unit_assert.svh =====
// ----------------------------------------------------------------------------
// LED strip wave engine assertion macros
// Shared property forms for the wave engine checks.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_WAVE_ENGINE_UNIT_ASSERT_SVH
`define LED_STRIP_WAVE_ENGINE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LSWE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lswe check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define LSWE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lswe check failed");
`endif

// ===== hdl/lswe_pkg.sv =====
// ----------------------------------------------------------------------------
// LED strip wave engine package
// Types, constants and codes shared by the wave engine files.
// ----------------------------------------------------------------------------
package lswe_pkg;
   localparam int MAX_PIXELS_DEFAULT = 256;
   localparam logic [11:0] LEVEL_MAX = 12'd2550;

   typedef enum logic [1:0] {
      CMD_WAVE = 2'd0,
      CMD_SET  = 2'd1,
      CMD_FILL = 2'd2,
      CMD_READ = 2'd3
   } cmd_type;

   typedef enum logic {
      REG_STRIP_LAST = 1'b0,
      REG_PAINT      = 1'b1
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_WAVE_PRE,
      ST_PCLEAR,
      ST_WALK_RD,
      ST_WALK_UPD,
      ST_ADD_R_RD,
      ST_ADD_R_WR,
      ST_ADD_L_RD,
      ST_ADD_L_WR,
      ST_INJ_RD,
      ST_INJ_WR,
      ST_FILL,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [1:0]  channel;
      logic [7:0]  pulse_level;
      logic [7:0]  interval_ms;
      logic [7:0]  fade_step;
      logic [7:0]  position;
      logic [7:0]  red_in;
      logic [7:0]  green_in;
      logic [7:0]  blue_in;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [11:0] red_out;
      logic [11:0] green_out;
      logic [11:0] blue_out;
      logic        wave_advanced;
   } rsp_type;

   function automatic logic [11:0] times_ten(input logic [7:0] v);
      return ({4'd0, v} << 3) + ({4'd0, v} << 1);
   endfunction

   function automatic logic [11:0] sat_add(input logic [11:0] a, input logic [11:0] b);
      logic [12:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : s[11:0];
   endfunction
endpackage

// ===== hdl/led_strip_wave_engine_unit.sv =====
// ----------------------------------------------------------------------------
// LED strip wave engine
// Frame store of three color planes with one ring of wave pulses per color.
// ----------------------------------------------------------------------------
// One item is taken at a time; ready is low from its transfer until the cycle
// after its result has been transferred, and also while a configuration write
// is offered. After reset and after every strip_last_index write, a clearing
// pass walks the ring and pixel memories. With L the effective last index, the
// steps of an item before its result is offered are: a set writes the three
// planes of its pixel in turn, a read fetches the three planes, a wave on
// channel three does nothing, an early wave records its level (and paints its
// pixel when paint is on), a fill writes all three planes of pixels 0 to L,
// and a running wave stores the pulse, clears its plane, then fades and moves
// each of the 3*(L+1) older ring entries, adding its level at its moved edges via
// the single read-modify-write port of the pixel memory, and injects the pulse.
module led_strip_wave_engine_unit #(
   parameter int MAX_PIXELS = lswe_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lswe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lswe_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [7:0]        csr_data
);
   import lswe_pkg::*;
`include "led_strip_wave_engine_unit_assert.svh"

   localparam int RING = 3 * MAX_PIXELS + 1;
   localparam int PW = $clog2(MAX_PIXELS);
   localparam int RW = $clog2(RING);
   localparam int RAW = $clog2(3 * RING);
   localparam int PAW = $clog2(3 * MAX_PIXELS);
   localparam int CW = $clog2(3 * RING + 1);

   logic [11:0] lvl_mem [3 * RING];
   logic [7:0]  rpos_mem [3 * RING];
   logic [7:0]  lpos_mem [3 * RING];
   logic [11:0] pix_mem [3 * MAX_PIXELS];

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   rsp_type     rsp_ff, rsp_in;
   logic [7:0]  last_idx_ff, last_idx_in;
   logic        paint_ff, paint_in;
   logic [RW-1:0] slot_ff [3];
   logic [RW-1:0] slot_in [3];
   logic [31:0] ltime_ff [3];
   logic [31:0] ltime_in [3];
   logic [7:0]  llvl_ff [3];
   logic [7:0]  llvl_in [3];
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] idx_ff, idx_in;
   logic [1:0]  pl_ff, pl_in;
   logic [11:0] v_ff, v_in;
   logic [7:0]  rp_ff, rp_in, lp_ff, lp_in;
   logic        mv_r_ff, mv_r_in, mv_l_ff, mv_l_in;

   logic [11:0] lvl_rd, pix_rd;
   logic [7:0]  rpos_rd, lpos_rd;
   logic        ring_we, pix_we;
   logic [RAW-1:0] ring_addr;
   logic [11:0] ring_wlvl;
   logic [7:0]  ring_wr, ring_wl;
   logic [PAW-1:0] pix_addr;
   logic [11:0] pix_wdata;

   logic [PW-1:0] eff_last;
   logic [RW:0]   ring_len;
   logic [1:0]    ch;
   logic          in_store;
   logic          wave_early;

   assign eff_last = ({24'd0, last_idx_ff} >= 32'(MAX_PIXELS)) ? PW'(MAX_PIXELS - 1)
                                                               : PW'(last_idx_ff);
   assign ring_len = (RW + 1)'(3 * ({2'd0, eff_last} + 1) + 1);
   assign ch = req_ff.channel;
   assign in_store = {24'd0, req_ff.position} < 32'(MAX_PIXELS);
   assign wave_early = (req_ff.now_ms - ltime_ff[ch]) < {24'd0, req_ff.interval_ms};

   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;
   assign csr_ready = (state_ff == ST_IDLE) || (state_ff == ST_CLEAR);

   function automatic logic [PAW-1:0] pa(input logic [1:0] c, input logic [7:0] p);
      return PAW'(p) * PAW'(3) + PAW'(c);
   endfunction

   always_ff @(posedge clock) begin
      if (ring_we) begin
         lvl_mem[ring_addr]  <= ring_wlvl;
         rpos_mem[ring_addr] <= ring_wr;
         lpos_mem[ring_addr] <= ring_wl;
      end
      lvl_rd  <= lvl_mem[ring_addr];
      rpos_rd <= rpos_mem[ring_addr];
      lpos_rd <= lpos_mem[ring_addr];
   end

   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[pix_addr] <= pix_wdata;
      end
      pix_rd <= pix_mem[pix_addr];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_valid && csr_index == REG_STRIP_LAST) begin
               state_in = ST_CLEAR;
            end else if (req_valid && !csr_valid) begin
               case (req_data.command)
                  CMD_WAVE: state_in = (req_data.channel < 2'd3) ? ST_WAVE_PRE : ST_RESP;
                  CMD_SET:  state_in = ST_FILL;
                  CMD_FILL: state_in = ST_FILL;
                  default:  state_in = ST_READ;
               endcase
            end
         end
         ST_CLEAR: begin
            if (cnt_ff == CW'(3 * RING - 1)) state_in = ST_IDLE;
         end
         ST_WAVE_PRE: state_in = wave_early ? (paint_ff ? ST_FILL : ST_RESP) : ST_PCLEAR;
         ST_PCLEAR: begin
            if (cnt_ff[PW:0] == {1'b0, eff_last}) state_in = ST_WALK_RD;
         end
         ST_WALK_RD: state_in = ST_WALK_UPD;
         ST_WALK_UPD: state_in = ST_ADD_R_RD;
         ST_ADD_R_RD: state_in = ST_ADD_R_WR;
         ST_ADD_R_WR: state_in = ST_ADD_L_RD;
         ST_ADD_L_RD: state_in = ST_ADD_L_WR;
         ST_ADD_L_WR: begin
            state_in = (cnt_ff == CW'(ring_len - 2)) ? ST_INJ_RD : ST_WALK_RD;
         end
         ST_INJ_RD: state_in = ST_INJ_WR;
         ST_INJ_WR: state_in = ST_RESP;
         ST_FILL: begin
            if (pl_ff == 2'd2 &&
                (req_ff.command != CMD_FILL || cnt_ff[PW:0] == {1'b0, eff_last})) begin
               state_in = ST_RESP;
            end
         end
         ST_READ: begin
            if (pl_ff == 2'd3) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_in = req_ff;
      rsp_in = rsp_ff;
      last_idx_in = last_idx_ff;
      paint_in = paint_ff;
      slot_in = slot_ff;
      ltime_in = ltime_ff;
      llvl_in = llvl_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      pl_in = pl_ff;
      v_in = v_ff;
      rp_in = rp_ff;
      lp_in = lp_ff;
      mv_r_in = mv_r_ff;
      mv_l_in = mv_l_ff;
      ring_we = 1'b0;
      ring_addr = RAW'(ch) * RAW'(RING) + RAW'(idx_ff);
      ring_wlvl = '0;
      ring_wr = '0;
      ring_wl = '0;
      pix_we = 1'b0;
      pix_addr = pa(pl_ff, 8'(cnt_ff));
      pix_wdata = '0;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (csr_valid) begin
               if (csr_index == REG_STRIP_LAST) begin
                  last_idx_in = csr_data;
                  for (int c = 0; c < 3; c++) slot_in[c] = '0;
               end else begin
                  paint_in = csr_data[0];
               end
            end else if (req_valid) begin
               req_in = req_data;
               rsp_in = '0;
               pl_in = '0;
            end
         end
         ST_CLEAR: begin
            ring_we = 1'b1;
            ring_addr = RAW'(cnt_ff);
            if (cnt_ff < CW'(3 * MAX_PIXELS)) begin
               pix_we = 1'b1;
               pix_addr = PAW'(cnt_ff);
            end
            cnt_in = cnt_ff + 1'b1;
            if (csr_valid && csr_index == REG_STRIP_LAST) begin
               last_idx_in = csr_data;
               cnt_in = '0;
            end else if (csr_valid) begin
               paint_in = csr_data[0];
            end
         end
         ST_WAVE_PRE: begin
            llvl_in[ch] = req_ff.pulse_level;
            cnt_in = '0;
            if (wave_early) begin
               req_in.red_in = (ch == 2'd0) ? req_ff.pulse_level : llvl_ff[0];
               req_in.green_in = (ch == 2'd1) ? req_ff.pulse_level : llvl_ff[1];
               req_in.blue_in = (ch == 2'd2) ? req_ff.pulse_level : llvl_ff[2];
               req_in.command = CMD_SET;
            end else begin
               ltime_in[ch] = req_ff.now_ms;
               ring_we = 1'b1;
               ring_addr = RAW'(ch) * RAW'(RING) + RAW'(slot_ff[ch]);
               ring_wlvl = times_ten(req_ff.pulse_level);
               ring_wr = req_ff.position;
               ring_wl = req_ff.position;
               idx_in = ({1'b0, slot_ff[ch]} + 1'b1 >= ring_len) ? '0 : slot_ff[ch] + 1'b1;
               slot_in[ch] = idx_in;
               rsp_in.wave_advanced = 1'b1;
            end
         end
         ST_PCLEAR: begin
            pix_we = 1'b1;
            pix_addr = pa(ch, 8'(cnt_ff));
            cnt_in = (cnt_ff[PW:0] == {1'b0, eff_last}) ? '0 : cnt_ff + 1'b1;
         end
         ST_WALK_RD: begin
         end
         ST_WALK_UPD: begin
            v_in = ({4'd0, req_ff.fade_step} < lvl_rd) ? lvl_rd - {4'd0, req_ff.fade_step} : '0;
            mv_r_in = ({1'b0, rpos_rd} + 1'b1 <= {1'b0, 8'(eff_last)});
            mv_l_in = (lpos_rd > 8'd0);
            rp_in = mv_r_in ? rpos_rd + 1'b1 : rpos_rd;
            lp_in = mv_l_in ? lpos_rd - 1'b1 : lpos_rd;
            ring_we = 1'b1;
            ring_wlvl = v_in;
            ring_wr = rp_in;
            ring_wl = lp_in;
         end
         ST_ADD_R_RD: pix_addr = pa(ch, rp_ff);
         ST_ADD_R_WR: begin
            pix_addr = pa(ch, rp_ff);
            pix_wdata = sat_add(pix_rd, v_ff);
            pix_we = mv_r_ff;
         end
         ST_ADD_L_RD: pix_addr = pa(ch, lp_ff);
         ST_ADD_L_WR: begin
            pix_addr = pa(ch, lp_ff);
            pix_wdata = sat_add(pix_rd, v_ff);
            pix_we = mv_l_ff && ({24'd0, lp_ff} < 32'(MAX_PIXELS));
            cnt_in = cnt_ff + 1'b1;
            idx_in = ({1'b0, idx_ff} + 1'b1 >= ring_len) ? '0 : idx_ff + 1'b1;
         end
         ST_INJ_RD: pix_addr = pa(ch, req_ff.position);
         ST_INJ_WR: begin
            pix_addr = pa(ch, req_ff.position);
            pix_wdata = sat_add(pix_rd, times_ten(req_ff.pulse_level));
            pix_we = in_store;
         end
         ST_FILL: begin
            pix_addr = pa(pl_ff, (req_ff.command == CMD_FILL) ? 8'(cnt_ff) : req_ff.position);
            pix_we = (req_ff.command == CMD_FILL) || in_store;
            case (pl_ff)
               2'd0: pix_wdata = times_ten(req_ff.red_in);
               2'd1: pix_wdata = times_ten(req_ff.green_in);
               default: pix_wdata = times_ten(req_ff.blue_in);
            endcase
            if (pl_ff == 2'd2) begin
               pl_in = '0;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               pl_in = pl_ff + 1'b1;
            end
         end
         ST_READ: begin
            pix_addr = pa((pl_ff == 2'd3) ? 2'd2 : pl_ff, req_ff.position);
            pl_in = pl_ff + 1'b1;
            if (in_store) begin
               case (pl_ff)
                  2'd1: rsp_in.red_out = pix_rd;
                  2'd2: rsp_in.green_out = pix_rd;
                  2'd3: rsp_in.blue_out = pix_rd;
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         last_idx_ff <= '0;
         paint_ff <= 1'b0;
         cnt_ff <= '0;
         pl_ff <= '0;
         for (int c = 0; c < 3; c++) begin
            slot_ff[c] <= '0;
            ltime_ff[c] <= '0;
            llvl_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         last_idx_ff <= last_idx_in;
         paint_ff <= paint_in;
         cnt_ff <= cnt_in;
         pl_ff <= pl_in;
         slot_ff <= slot_in;
         ltime_ff <= ltime_in;
         llvl_ff <= llvl_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
      v_ff <= v_in;
      rp_ff <= rp_in;
      lp_ff <= lp_in;
      mv_r_ff <= mv_r_in;
      mv_l_ff <= mv_l_in;
   end

   `LSWE_ASSERT_IMP(a_rsp_only_in_resp, clock, reset, rsp_valid, !req_ready)
   `LSWE_ASSERT_NEXT(a_rsp_done, clock, reset, rsp_valid && rsp_ready, !rsp_valid)
   `LSWE_ASSERT_IMP(a_read_no_wave, clock, reset,
      rsp_valid && rsp_data.wave_advanced, rsp_data.red_out == 12'd0)
   `LSWE_ASSERT_IMP(a_level_cap, clock, reset, rsp_valid,
      rsp_data.red_out <= LEVEL_MAX && rsp_data.blue_out <= LEVEL_MAX)
endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// LED strip wave engine testbench
// Drives pixel, fill, read and wave commands through the request channel,
// predicts every response from a behavioral model of the frame store and the
// pulse rings, and compares each response field by field. The run steps
// through several strip lengths and paint settings under varied back-pressure.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lswe_pkg::*;

   localparam int PIXELS = 256;
   localparam int RING = 3 * PIXELS + 1;

   class wave_scoreboard;
      logic [11:0] pulse_lvl [3][RING];
      logic [7:0]  pulse_rt [3][RING];
      logic [7:0]  pulse_lt [3][RING];
      logic [11:0] plane [PIXELS][3];
      int          slot [3];
      logic [31:0] wave_time [3];
      logic [7:0]  recent_lvl [3];
      int          strip_last;
      bit          paint_early;
      rsp_type     expected_rsps [$];
      int          errors;

      function void clear_store();
         for (int c = 0; c < 3; c++) begin
            slot[c] = 0;
            for (int i = 0; i < RING; i++) begin
               pulse_lvl[c][i] = '0;
               pulse_rt[c][i] = '0;
               pulse_lt[c][i] = '0;
            end
         end
         for (int p = 0; p < PIXELS; p++)
            for (int c = 0; c < 3; c++) plane[p][c] = '0;
      endfunction

      function new();
         clear_store();
         for (int c = 0; c < 3; c++) begin
            wave_time[c] = '0;
            recent_lvl[c] = '0;
         end
         strip_last = 0;
         paint_early = 0;
         errors = 0;
      endfunction

      function void configure(reg_type idx, logic [7:0] val);
         if (idx == REG_STRIP_LAST) begin
            strip_last = val;
            clear_store();
         end else begin
            paint_early = val[0];
         end
      endfunction

      function void add_level(int pos, int ch, int lvl);
         int s;
         s = plane[pos][ch] + lvl;
         plane[pos][ch] = (s > 2550) ? 12'd2550 : s[11:0];
      endfunction

      function void paint(int pos, logic [7:0] r, logic [7:0] g, logic [7:0] b);
         plane[pos][0] = 12'(r) * 12'd10;
         plane[pos][1] = 12'(g) * 12'd10;
         plane[pos][2] = 12'(b) * 12'd10;
      endfunction

      function bit wave_step(req_type r);
         int ch, ring_len, row, idx, v, p;
         logic [31:0] elapsed;
         ch = r.channel;
         ring_len = (strip_last + 1) * 3 + 1;
         recent_lvl[ch] = r.pulse_level;
         elapsed = r.now_ms - wave_time[ch];
         if (elapsed < r.interval_ms) begin
            if (paint_early) paint(r.position, recent_lvl[0], recent_lvl[1], recent_lvl[2]);
            return 0;
         end
         wave_time[ch] = r.now_ms;
         row = slot[ch] % ring_len;
         pulse_lvl[ch][row] = 12'(r.pulse_level) * 12'd10;
         pulse_lt[ch][row] = r.position;
         pulse_rt[ch][row] = r.position;
         row = (row + 1) % ring_len;
         slot[ch] = row;
         for (int q = 0; q <= strip_last; q++) plane[q][ch] = '0;
         for (int j = 0; j < ring_len - 1; j++) begin
            idx = (row + j) % ring_len;
            v = pulse_lvl[ch][idx];
            v = (r.fade_step < v) ? v - r.fade_step : 0;
            pulse_lvl[ch][idx] = 12'(v);
            p = pulse_rt[ch][idx];
            if (p + 1 <= strip_last) begin
               pulse_rt[ch][idx] = 8'(p + 1);
               add_level(p + 1, ch, v);
            end
            p = pulse_lt[ch][idx];
            if (p > 0) begin
               pulse_lt[ch][idx] = 8'(p - 1);
               add_level(p - 1, ch, v);
            end
         end
         add_level(r.position, ch, r.pulse_level * 10);
         return 1;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         e = '0;
         case (cmd_type'(r.command))
            CMD_WAVE: if (r.channel < 3) e.wave_advanced = wave_step(r);
            CMD_SET:  paint(r.position, r.red_in, r.green_in, r.blue_in);
            CMD_FILL: for (int p = 0; p <= strip_last; p++)
                         paint(p, r.red_in, r.green_in, r.blue_in);
            default: begin
               e.red_out = plane[r.position][0];
               e.green_out = plane[r.position][1];
               e.blue_out = plane[r.position][2];
            end
         endcase
         expected_rsps.push_back(e);
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      task check_response(rsp_type got);
         rsp_type e;
         if (expected_rsps.size() == 0) begin
            report("response with none pending");
            return;
         end
         e = expected_rsps.pop_front();
         if (got.red_out !== e.red_out)
            report($sformatf("red_out got %0d exp %0d", got.red_out, e.red_out));
         if (got.green_out !== e.green_out)
            report($sformatf("green_out got %0d exp %0d", got.green_out, e.green_out));
         if (got.blue_out !== e.blue_out)
            report($sformatf("blue_out got %0d exp %0d", got.blue_out, e.blue_out));
         if (got.wave_advanced !== e.wave_advanced)
            report($sformatf("wave_advanced got %0d exp %0d",
                             got.wave_advanced, e.wave_advanced));
      endtask
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;
   logic    csr_valid = 0;
   logic    csr_ready;
   logic    csr_index = 0;
   logic [7:0] csr_data = '0;

   wave_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_on = 0;
   event long_stall;
   logic [31:0] clock_ms = 0;
   int strip_now = 0;

   led_strip_wave_engine_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
      if (hold_on) begin
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always begin
      @(long_stall);
      hold_on <= 1'b1;
      repeat (400) @(posedge clock);
      hold_on <= 1'b0;
   end

   task send_request(req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
      req_valid <= 0;
      @(posedge clock);
   endtask

   task write_reg(reg_type idx, logic [7:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.configure(idx, val);
      csr_valid <= 0;
      if (idx == REG_STRIP_LAST) strip_now = val;
      @(posedge clock);
   endtask

   task drain_responses();
      while (sb.expected_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function req_type make_cmd(cmd_type c, int ch, int lvl, int ivl, int fade, int pos,
                              logic [31:0] now);
      req_type r;
      r = '0;
      r.command = c;
      r.channel = 2'(ch);
      r.pulse_level = 8'(lvl);
      r.interval_ms = 8'(ivl);
      r.fade_step = 8'(fade);
      r.position = 8'(pos);
      r.red_in = 8'($urandom);
      r.green_in = 8'($urandom);
      r.blue_in = 8'($urandom);
      r.now_ms = now;
      return r;
   endfunction

   function req_type random_request();
      req_type r;
      logic [95:0] raw;
      int pick;
      raw = {$urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      pick = $urandom_range(0, 99);
      r.command = (pick < 50) ? CMD_WAVE : (pick < 70) ? CMD_SET :
                  (pick < 80) ? CMD_FILL : CMD_READ;
      r.channel = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 4) != 0) r.position = 8'($urandom_range(0, strip_now));
      if ($urandom_range(0, 19) == 0) begin
         r.now_ms = $urandom;
      end else begin
         clock_ms = clock_ms + 32'($urandom_range(0, 300));
         r.now_ms = clock_ms;
      end
      return r;
   endfunction

   initial begin
      #60_000_000;
      $display("led_strip_wave_engine_unit verification failed");
      $finish;
   end

   initial begin
      int lens [6] = '{0, 7, 255, 1, 15, 3};
      int paints [6] = '{0, 1, 1, 0, 1, 0};
      int modes [6] = '{1, 2, 3, 3, 0, 1};
      int counts [6] = '{40, 50, 20, 50, 50, 40};
      int send_pct [4] = '{0, 64, 0, 15};
      int recv_pct [4] = '{0, 0, 64, 15};
      int waited;

      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_reg(REG_STRIP_LAST, 8'd3);
      write_reg(REG_PAINT, 8'd1);
      send_request(make_cmd(CMD_WAVE, 0, 255, 0, 0, 0, 32'd0));
      send_request(make_cmd(CMD_WAVE, 1, 128, 10, 255, 3, 32'd20));
      send_request(make_cmd(CMD_WAVE, 2, 0, 255, 0, 2, 32'd300));
      send_request(make_cmd(CMD_WAVE, 0, 200, 255, 5, 1, 32'd10));
      send_request(make_cmd(CMD_WAVE, 0, 255, 0, 1, 2, 32'd11));
      send_request(make_cmd(CMD_WAVE, 3, 255, 0, 0, 1, 32'd500));
      send_request(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 32'd0));
      send_request(make_cmd(CMD_READ, 0, 0, 0, 0, 1, 32'd0));
      send_request(make_cmd(CMD_READ, 0, 0, 0, 0, 2, 32'd0));
      send_request(make_cmd(CMD_READ, 0, 0, 0, 0, 3, 32'd0));
      send_request(make_cmd(CMD_SET, 0, 0, 0, 0, 255, 32'd0));
      send_request(make_cmd(CMD_READ, 0, 0, 0, 0, 255, 32'd0));
      send_request(make_cmd(CMD_WAVE, 1, 17, 200, 0, 254, 32'hFFFF_FFF0));
      send_request(make_cmd(CMD_WAVE, 1, 99, 30, 0, 1, 32'd5));
      send_request(make_cmd(CMD_WAVE, 1, 99, 255, 0, 2, 32'd6));
      send_request(make_cmd(CMD_READ, 0, 0, 0, 0, 254, 32'd0));
      send_request(make_cmd(CMD_FILL, 0, 0, 0, 0, 0, 32'd0));
      send_request(make_cmd(CMD_WAVE, 2, 255, 0, 0, 3, 32'd1000));
      send_request(make_cmd(CMD_READ, 0, 0, 0, 0, 3, 32'd0));
      send_request(make_cmd(CMD_READ, 0, 0, 0, 0, 255, 32'd0));
      clock_ms = 32'd2000;

      for (int ph = 0; ph < 6; ph++) begin
         drain_responses();
         send_idle_pct = 0;
         recv_stall_pct = 0;
         write_reg(REG_STRIP_LAST, 8'(lens[ph]));
         write_reg(REG_PAINT, 8'(paints[ph]));
         send_idle_pct = send_pct[modes[ph]];
         recv_stall_pct = recv_pct[modes[ph]];
         for (int n = 0; n < counts[ph]; n++) begin
            if (ph == 4 && n == 10) -> long_stall;
            if (ph == 4 && n == 30) drain_responses();
            send_request(random_request());
         end
      end

      waited = 0;
      while (sb.expected_rsps.size() != 0 && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (sb.expected_rsps.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.expected_rsps.size()));
      if (sb.errors == 0)
         $display("led_strip_wave_engine_unit verification clean");
      else
         $display("led_strip_wave_engine_unit verification failed");
      $finish;
   end
endmodule
